// ===== hw/rtl/ptst_pkg.sv =====
// Package for the periodic schedule table block: sizes, codes and transfer types.
// No dependencies; imported by every module of the block except ptst_ram.
package ptst_pkg;

  localparam int unsigned NUM_TABLES       = 4;
  localparam int unsigned EVENTS_PER_TABLE = 8;
  localparam int unsigned TICK_SCALE       = 1;

  localparam int unsigned NUM_EVENTS = NUM_TABLES * EVENTS_PER_TABLE;
  localparam int unsigned TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned EVT_W      = (EVENTS_PER_TABLE > 1) ? $clog2(EVENTS_PER_TABLE) : 1;
  localparam int unsigned EV_IDX_W   = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int unsigned TS_W       = $clog2(TICK_SCALE + 1);
  localparam int unsigned PROD_W     = 17 + TS_W;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_HEADER = 3'd3,
    CMD_EVENT  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_BAD_TRANSITION = 2'd1,
    ST_UNKNOWN_ID     = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  table_slot;
    logic [2:0]  event_slot;
    logic [15:0] table_ident;
    logic [3:0]  event_total;
    logic        start_active;
    logic [15:0] timeout_ms;
    logic [7:0]  task_number;
  } in_item_t;

  typedef struct packed {
    logic       is_activation;
    logic [7:0] task_out;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  task_id;
    logic [15:0] count;
  } evt_word_t;

  localparam int unsigned EVT_WORD_W = $bits(evt_word_t);

  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic walk_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/periodic_task_schedule_table.sv =====
// Top level of the periodic schedule table block: sequencer plus datapath.
// Depends on ptst_pkg, ptst_ctrl, ptst_dp (and ptst_ram through ptst_dp).
//
// Channel  Ports                          Transfer
// input    start, busy, in_data           rising edge with start high, busy low
// result   out_strobe, out_data           every cycle out_strobe is high
//
// A tick holds busy through the walk of every event RAM entry and the flush and
// finish states: one entry is read per cycle, with the counter update written
// back in the following cycle. Other commands go straight to the finish state.
// Results leave a register in the cycle after they are formed; the final status
// result shows as busy drops. Reset is synchronous; the event RAM needs no
// clearing pass, entries read as zero until written. The receiver cannot stall.
module periodic_task_schedule_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  ptst_pkg::in_item_t   in_data,
  output logic                 busy,
  output logic                 out_strobe,
  output ptst_pkg::out_item_t  out_data
);

  import ptst_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;
  logic     is_tick;

  assign is_tick = (in_data.cmd == CMD_TICK);

  ptst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .is_tick (is_tick),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  ptst_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .ctl        (ctl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe && out_data.last)
    else $error("command finished without final status transfer");

  a_act_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.is_activation |-> busy && !out_data.last)
    else $error("activation transfer outside a tick walk");

endmodule

// ===== hw/rtl/ptst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/ptst_ctrl.sv =====
// Sequencer for the schedule table block: accepts commands, runs the tick walk.
// Depends on ptst_pkg.
module ptst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                is_tick,
  input  ptst_pkg::dp_stat_t  stat,
  output ptst_pkg::ctl_cmd_t  ctl,
  output logic                busy
);

  import ptst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = is_tick ? S_WALK : S_FIN;
        end
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/ptst_dp.sv =====
// Datapath: table registers, event RAM with read-modify-write pipe, result register.
// Depends on ptst_pkg and ptst_ram.
module ptst_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptst_pkg::in_item_t   in_data,
  input  ptst_pkg::ctl_cmd_t   ctl,
  output ptst_pkg::dp_stat_t   stat,
  output logic                 out_strobe,
  output ptst_pkg::out_item_t  out_data
);

  import ptst_pkg::*;

  in_item_t              item_r;
  logic [TBL_W-1:0]      t_r;
  logic [EVT_W-1:0]      e_r;
  logic [NUM_TABLES-1:0] tbl_act_r;
  logic [15:0]           tbl_id_r  [NUM_TABLES];
  logic [3:0]            tbl_cnt_r [NUM_TABLES];
  logic [NUM_EVENTS-1:0] evt_vld_r;
  logic                  upd_v_r;
  logic [EV_IDX_W-1:0]   upd_idx_r;
  logic                  out_strobe_r;
  out_item_t             out_data_r;

  logic [EV_IDX_W-1:0]   walk_addr;
  logic                  walk_en;
  logic [EV_IDX_W-1:0]   wr_idx;
  logic                  wr_ok;
  logic                  hdr_ok;
  logic                  hit;
  logic [TBL_W-1:0]      hit_idx;
  logic [TBL_W-1:0]      hdr_idx;
  status_t               status;
  logic                  st_from;
  logic                  is_chg;

  logic [EVT_WORD_W-1:0] rd_bits;
  evt_word_t             cur;
  logic [15:0]           cnt1;
  logic [PROD_W-1:0]     prod;
  logic                  fire;
  logic                  ram_we;
  logic [EV_IDX_W-1:0]   ram_waddr;
  evt_word_t             ram_wdata;

  assign walk_addr = EV_IDX_W'(int'(t_r) * EVENTS_PER_TABLE + int'(e_r));
  assign walk_en   = tbl_act_r[t_r] && (int'(e_r) < int'(tbl_cnt_r[t_r]));
  assign stat.walk_last = (t_r == TBL_W'(NUM_TABLES - 1)) &&
                          (e_r == EVT_W'(EVENTS_PER_TABLE - 1));

  assign hdr_ok = int'(item_r.table_slot) < NUM_TABLES;
  assign wr_ok  = hdr_ok && (int'(item_r.event_slot) < EVENTS_PER_TABLE);
  assign hdr_idx = TBL_W'(item_r.table_slot);
  assign wr_idx  = EV_IDX_W'(int'(item_r.table_slot) * EVENTS_PER_TABLE +
                             int'(item_r.event_slot));

  // lowest matching table slot
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_TABLES - 1; i >= 0; i--) begin
      if (tbl_id_r[i] == item_r.table_ident) begin
        hit     = 1'b1;
        hit_idx = TBL_W'(i);
      end
    end
  end

  assign is_chg  = (item_r.cmd == CMD_START) || (item_r.cmd == CMD_STOP);
  assign st_from = (item_r.cmd == CMD_STOP);

  always_comb begin
    status = ST_OK;
    if (is_chg) begin
      priority if (!hit) begin
        status = ST_UNKNOWN_ID;
      end else if (tbl_act_r[hit_idx] != st_from) begin
        status = ST_BAD_TRANSITION;
      end else begin
        status = ST_OK;
      end
    end
  end

  // counter update; fire when (cnt1 + 1) * TICK_SCALE > period
  assign cur  = evt_vld_r[upd_idx_r] ? evt_word_t'(rd_bits) : '0;
  assign cnt1 = cur.count + 16'd1;
  assign prod = (PROD_W'(cnt1) + PROD_W'(1)) * PROD_W'(TICK_SCALE);
  assign fire = prod > PROD_W'(cur.period);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = upd_idx_r;
    ram_wdata = '{period: cur.period, task_id: cur.task_id,
                  count: (fire ? 16'd0 : cnt1)};
    if (upd_v_r) begin
      ram_we = 1'b1;
    end else if (ctl.finish && (item_r.cmd == CMD_EVENT) && wr_ok) begin
      ram_we    = 1'b1;
      ram_waddr = wr_idx;
      ram_wdata = '{period: item_r.timeout_ms, task_id: item_r.task_number,
                    count: 16'd0};
    end
  end

  ptst_ram #(
    .WIDTH (EVT_WORD_W),
    .DEPTH (NUM_EVENTS)
  ) u_evt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_addr),
    .rdata (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
    end
    upd_idx_r <= walk_addr;
    if (upd_v_r && fire) begin
      out_data_r <= '{is_activation: 1'b1, task_out: cur.task_id,
                      status: ST_OK, last: 1'b0};
    end else begin
      out_data_r <= '{is_activation: 1'b0, task_out: 8'd0,
                      status: status, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r          <= '0;
      e_r          <= '0;
      tbl_act_r    <= '0;
      evt_vld_r    <= '0;
      upd_v_r      <= 1'b0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        tbl_id_r[i]  <= '0;
        tbl_cnt_r[i] <= '0;
      end
    end else begin
      upd_v_r      <= ctl.walk && walk_en;
      out_strobe_r <= (upd_v_r && fire) || ctl.finish;
      if (ctl.load) begin
        t_r <= '0;
        e_r <= '0;
      end else if (ctl.walk && !stat.walk_last) begin
        if (e_r == EVT_W'(EVENTS_PER_TABLE - 1)) begin
          e_r <= '0;
          t_r <= t_r + TBL_W'(1);
        end else begin
          e_r <= e_r + EVT_W'(1);
        end
      end
      if (ctl.finish) begin
        if (is_chg && (status == ST_OK)) begin
          tbl_act_r[hit_idx] <= !st_from;
        end
        if ((item_r.cmd == CMD_HEADER) && hdr_ok) begin
          tbl_id_r[hdr_idx]  <= item_r.table_ident;
          tbl_cnt_r[hdr_idx] <= item_r.event_total;
          tbl_act_r[hdr_idx] <= item_r.start_active;
        end
        if ((item_r.cmd == CMD_EVENT) && wr_ok) begin
          evt_vld_r[wr_idx] <= 1'b1;
        end
      end
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== test/tb_top.sv =====
// Testbench for periodic_task_schedule_table: directed and random command traffic.
// Checks every result against a local table/event model; depends on ptst_pkg and periodic_task_schedule_table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptst_pkg::*;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST         = 3'd7;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = NUM_EVENTS + 8;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_data;

  periodic_task_schedule_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // local copy of the schedule tables
  logic        tbl_active [NUM_TABLES];
  logic [15:0] tbl_ident  [NUM_TABLES];
  logic [3:0]  tbl_events [NUM_TABLES];
  logic [15:0] ev_period  [NUM_EVENTS];
  logic [7:0]  ev_task    [NUM_EVENTS];
  logic [15:0] ev_count   [NUM_EVENTS];

  out_item_t expected_results[$];
  out_item_t want;
  int        errors = 0;
  int        idle_pct = 0;
  int        quiet_cycles = 0;

  task automatic clear_tables();
    for (int t = 0; t < NUM_TABLES; t++) begin
      tbl_active[t] = 1'b0;
      tbl_ident[t]  = '0;
      tbl_events[t] = '0;
    end
    for (int i = 0; i < NUM_EVENTS; i++) begin
      ev_period[i] = '0;
      ev_task[i]   = '0;
      ev_count[i]  = '0;
    end
  endtask

  function automatic int find_table(logic [15:0] id);
    for (int t = 0; t < NUM_TABLES; t++)
      if (tbl_ident[t] == id) return t;
    return NUM_TABLES;
  endfunction

  function automatic status_t change_state(logic [15:0] id, logic from_st, logic to_st);
    int t;
    t = find_table(id);
    if (t >= NUM_TABLES) return ST_UNKNOWN_ID;
    if (tbl_active[t] != from_st) return ST_BAD_TRANSITION;
    tbl_active[t] = to_st;
    return ST_OK;
  endfunction

  task automatic predict_results(input in_item_t it);
    out_item_t   r;
    status_t     st;
    int          n;
    int          idx;
    int unsigned thr;
    st = ST_OK;
    case (it.cmd)
      CMD_TICK: begin
        for (int t = 0; t < NUM_TABLES; t++) begin
          if (tbl_active[t]) begin
            n = (tbl_events[t] > EVENTS_PER_TABLE) ? EVENTS_PER_TABLE : tbl_events[t];
            for (int e = 0; e < n; e++) begin
              idx = t * EVENTS_PER_TABLE + e;
              thr = ev_period[idx] / TICK_SCALE;
              ev_count[idx] = ev_count[idx] + 16'd1;
              if (ev_count[idx] >= thr) begin
                r.is_activation = 1'b1;
                r.task_out      = ev_task[idx];
                r.status        = ST_OK;
                r.last          = 1'b0;
                expected_results.push_back(r);
                ev_count[idx] = '0;
              end
            end
          end
        end
      end
      CMD_START: st = change_state(it.table_ident, 1'b0, 1'b1);
      CMD_STOP:  st = change_state(it.table_ident, 1'b1, 1'b0);
      CMD_HEADER: begin
        if (it.table_slot < NUM_TABLES) begin
          tbl_ident[it.table_slot]  = it.table_ident;
          tbl_events[it.table_slot] = it.event_total;
          tbl_active[it.table_slot] = it.start_active;
        end
      end
      CMD_EVENT: begin
        if (it.table_slot < NUM_TABLES && it.event_slot < EVENTS_PER_TABLE) begin
          idx = it.table_slot * EVENTS_PER_TABLE + it.event_slot;
          ev_period[idx] = it.timeout_ms;
          ev_task[idx]   = it.task_number;
          ev_count[idx]  = '0;
        end
      end
      default: ;
    endcase
    r.is_activation = 1'b0;
    r.task_out      = '0;
    r.status        = st;
    r.last          = 1'b1;
    expected_results.push_back(r);
  endtask

  // start stays high across back-to-back transfers
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    predict_results(it);
  endtask

  function automatic in_item_t noise();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t cmd_item(logic [2:0] cmd, logic [15:0] id);
    in_item_t it;
    it = noise();
    it.cmd = cmd;
    it.table_ident = id;
    return it;
  endfunction

  function automatic in_item_t header_item(logic [1:0] slot, logic [15:0] id,
                                           logic [3:0] total, logic act);
    in_item_t it;
    it = noise();
    it.cmd          = CMD_HEADER;
    it.table_slot   = slot;
    it.table_ident  = id;
    it.event_total  = total;
    it.start_active = act;
    return it;
  endfunction

  function automatic in_item_t event_item(logic [1:0] tslot, logic [2:0] eslot,
                                          logic [15:0] tmo, logic [7:0] tsk);
    in_item_t it;
    it = noise();
    it.cmd         = CMD_EVENT;
    it.table_slot  = tslot;
    it.event_slot  = eslot;
    it.timeout_ms  = tmo;
    it.task_number = tsk;
    return it;
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8001;
      3: return 16'h7FFE;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       sel;
    it = noise();
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      it.cmd = CMD_TICK;
    end else if (sel < 52) begin
      it.cmd = CMD_START;
      it.table_ident = pick_id();
    end else if (sel < 64) begin
      it.cmd = CMD_STOP;
      it.table_ident = pick_id();
    end else if (sel < 74) begin
      it.cmd = CMD_HEADER;
      it.table_ident = pick_id();
      if ($urandom_range(0, 9) != 0) it.event_total = 4'($urandom_range(0, 8));
    end else if (sel < 96) begin
      it.cmd = CMD_EVENT;
      if ($urandom_range(0, 19) != 0) it.timeout_ms = 16'($urandom_range(0, 6));
    end else begin
      it.cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST));
    end
    return it;
  endfunction

  task automatic test_idle_tables();
    send_item(cmd_item(CMD_TICK, 16'h0000));
    send_item(cmd_item(CMD_STOP, 16'h0000));
    send_item(cmd_item(CMD_START, 16'hFFFF));
  endtask

  task automatic test_table_load();
    send_item(header_item(2'd0, 16'hFFFF, 4'hF, 1'b0));
    send_item(header_item(2'd3, 16'h0001, 4'd8, 1'b1));
    send_item(header_item(2'd1, 16'hFFFF, 4'd2, 1'b0));
    send_item(event_item(2'd0, 3'd7, 16'h0000, 8'hFF));
    send_item(event_item(2'd0, 3'd0, 16'd2, 8'h5A));
    send_item(event_item(2'd3, 3'd0, 16'hFFFF, 8'hA5));
    send_item(event_item(2'd3, 3'd7, 16'd1, 8'h01));
  endtask

  task automatic test_start_stop();
    send_item(cmd_item(CMD_START, 16'hFFFF));
    send_item(cmd_item(CMD_START, 16'hFFFF));
  endtask

  task automatic test_tick_activations();
    repeat (3) send_item(cmd_item(CMD_TICK, 16'($urandom)));
    send_item(cmd_item(CMD_STOP, 16'hFFFF));
    send_item(cmd_item(CMD_STOP, 16'hFFFF));
    send_item(cmd_item(CMD_STOP, 16'h0001));
  endtask

  task automatic test_unused_commands();
    for (logic [3:0] c = CMD_FIRST_UNUSED; c <= CMD_LAST; c++)
      send_item(cmd_item(c[2:0], 16'($urandom)));
    send_item(cmd_item(CMD_TICK, 16'h0000));
  endtask

  task automatic test_header_keeps_counters();
    send_item(header_item(2'd0, 16'hFFFF, 4'hF, 1'b1));
    send_item(cmd_item(CMD_TICK, 16'hFFFF));
  endtask

  task automatic test_random_traffic(input int count, input int pct);
    idle_pct = pct;
    repeat (count) send_item(rand_item());
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: task_out %0d status %0d", out_data.task_out,
               out_data.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.is_activation !== want.is_activation) begin
          $error("is_activation: expected %0d, got %0d", want.is_activation,
                 out_data.is_activation);
          errors++;
        end
        if (out_data.task_out !== want.task_out) begin
          $error("task_out: expected %0d, got %0d", want.task_out, out_data.task_out);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clear_tables();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 11;
    test_idle_tables();
    test_table_load();
    test_start_stop();
    test_tick_activations();
    test_unused_commands();
    test_header_keeps_counters();
    test_random_traffic(170, 11);
    test_random_traffic(170, 61);
    test_random_traffic(170, 0);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
